// ===== hw/rtl/hesc_pkg.sv =====
// Shared types and constants for the HTML escape stream block.
// Holds the command format between front and back ends and the entity tables.
// Depends on nothing.
`default_nettype none

package hesc_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_NUL  = 8'h00;

	localparam logic [2:0] LEN_QUOT  = 3'd6;
	localparam logic [2:0] LEN_AMP   = 3'd5;
	localparam logic [2:0] LEN_LTGT  = 3'd4;
	localparam logic [2:0] LEN_PLAIN = 3'd1;

	localparam logic [2:0] KIND_PLAIN = 3'd0;
	localparam logic [2:0] KIND_QUOT  = 3'd1;
	localparam logic [2:0] KIND_AMP   = 3'd2;
	localparam logic [2:0] KIND_LT    = 3'd3;
	localparam logic [2:0] KIND_GT    = 3'd4;
	localparam logic [2:0] KIND_TERM  = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data;
		logic [15:0] count;
	} cmd_t;

	function automatic logic [2:0] kind_len(input logic [2:0] kind);
		logic [2:0] len;
		unique case (kind)
			KIND_QUOT: len = LEN_QUOT;
			KIND_AMP:  len = LEN_AMP;
			KIND_LT:   len = LEN_LTGT;
			KIND_GT:   len = LEN_LTGT;
			default:   len = LEN_PLAIN;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] ent_char(input logic [2:0] kind, input logic [2:0] idx);
		logic [7:0] c;
		c = 8'h3B;
		if (idx == 3'd0) begin
			c = CH_AMP;
		end else begin
			unique case (kind)
				KIND_QUOT: begin
					unique case (idx)
						3'd1: c = 8'h71;
						3'd2: c = 8'h75;
						3'd3: c = 8'h6F;
						3'd4: c = 8'h74;
						default: c = 8'h3B;
					endcase
				end
				KIND_AMP: begin
					unique case (idx)
						3'd1: c = 8'h61;
						3'd2: c = 8'h6D;
						3'd3: c = 8'h70;
						default: c = 8'h3B;
					endcase
				end
				KIND_LT: begin
					unique case (idx)
						3'd1: c = 8'h6C;
						3'd2: c = 8'h74;
						default: c = 8'h3B;
					endcase
				end
				KIND_GT: begin
					unique case (idx)
						3'd1: c = 8'h67;
						3'd2: c = 8'h74;
						default: c = 8'h3B;
					endcase
				end
				default: c = 8'h3B;
			endcase
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hesc_front.sv =====
// Front end: accepts source bytes, tracks space and count per string, and
// issues one command per byte that produces output. Uses hesc_pkg.
`default_nettype none

module hesc_front #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_write,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           accept,
	input  wire logic [7:0]     in_byte,
	output hesc_pkg::cmd_t      cmd,
	output logic                cmd_push
);

	localparam logic [31:0] MASK32 = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

	logic [15:0]           buffer_size_q;
	logic [COUNT_BITS-1:0] space_q;
	logic [COUNT_BITS-1:0] written_q;
	logic                  open_q;
	logic                  stopped_q;

	logic [15:0]           bs_m1;
	logic [31:0]           bs_ext;
	logic [31:0]           bs_sat;
	logic [COUNT_BITS-1:0] sp;
	logic [COUNT_BITS-1:0] bw;
	logic                  stp;
	logic [2:0]            kind;
	logic [2:0]            len;
	logic [COUNT_BITS-1:0] len_ext;
	logic [COUNT_BITS-1:0] sp_next;
	logic                  fits;
	logic                  is_term;
	logic [31:0]           bw_ext;

	always_comb begin
		bs_m1  = (buffer_size_q == 16'd0) ? 16'd0 : buffer_size_q - 16'd1;
		bs_ext = 32'(bs_m1);
		bs_sat = (bs_ext > MASK32) ? MASK32 : bs_ext;
		sp     = open_q ? space_q : bs_sat[COUNT_BITS-1:0];
		bw     = open_q ? written_q : '0;
		stp    = open_q && stopped_q;
		is_term = (in_byte == hesc_pkg::CH_NUL);
		unique case (in_byte)
			hesc_pkg::CH_QUOT: kind = hesc_pkg::KIND_QUOT;
			hesc_pkg::CH_AMP:  kind = hesc_pkg::KIND_AMP;
			hesc_pkg::CH_LT:   kind = hesc_pkg::KIND_LT;
			hesc_pkg::CH_GT:   kind = hesc_pkg::KIND_GT;
			hesc_pkg::CH_NUL:  kind = hesc_pkg::KIND_TERM;
			default:           kind = hesc_pkg::KIND_PLAIN;
		endcase
		len     = hesc_pkg::kind_len(kind);
		len_ext = COUNT_BITS'(len);
		fits    = (sp >= len_ext);
		sp_next = sp - len_ext;
		bw_ext  = 32'(written_q);
	end

	always_comb begin
		cmd.kind  = kind;
		cmd.data  = in_byte;
		cmd.count = is_term ? bw_ext[15:0] : 16'd0;
		cmd_push  = accept && (is_term || (!stp && fits));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= 16'd256;
		end else if (cfg_write) begin
			buffer_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q   <= '0;
			written_q <= '0;
			open_q    <= 1'b0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (is_term) begin
				space_q   <= '0;
				written_q <= '0;
				open_q    <= 1'b0;
				stopped_q <= 1'b0;
			end else begin
				open_q    <= 1'b1;
				space_q   <= sp;
				written_q <= bw;
				stopped_q <= stp;
				if (!stp) begin
					if (!fits) begin
						stopped_q <= 1'b1;
					end else begin
						space_q   <= sp_next;
						written_q <= bw + len_ext;
						if (kind == hesc_pkg::KIND_PLAIN && sp_next == '0) begin
							stopped_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	a_stop_needs_open: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> open_q)
		else $error("output stopped while no string is open");

endmodule

`default_nettype wire

// ===== hw/rtl/hesc_queue.sv =====
// Short command queue between the front and back ends.
// Uses hesc_pkg for the command type and depth.
`default_nettype none

module hesc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire hesc_pkg::cmd_t wr_data,
	output logic                full,
	input  wire logic           pop,
	output hesc_pkg::cmd_t      rd_data,
	output logic                empty
);

	localparam int PTR_W = $clog2(hesc_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W:0] DEPTH_C = (PTR_W + 1)'(hesc_pkg::QUEUE_DEPTH);

	hesc_pkg::cmd_t   mem_q [hesc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == DEPTH_C);
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count exceeds its depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_ok && !push_ok) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count did not drop after a pop");

endmodule

`default_nettype wire

// ===== hw/rtl/hesc_back.sv =====
// Back end: expands queued commands into output bytes, one per cycle while the
// result stage is empty or popped, into a registered result stage. Uses hesc_pkg.
`default_nettype none

module hesc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hesc_pkg::cmd_t cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	output logic                empty,
	input  wire logic           pop,
	output logic [7:0]          out_byte,
	output logic                last_of_run,
	output logic                string_end,
	output logic [15:0]         written_count
);

	logic [2:0]  idx_q;
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        end_q;
	logic [15:0] count_q;

	logic [2:0]  len;
	logic        last;
	logic        is_term;
	logic        advance;
	logic [7:0]  next_byte;

	always_comb begin
		len       = hesc_pkg::kind_len(cmd.kind);
		last      = (idx_q == len - 3'd1);
		is_term   = (cmd.kind == hesc_pkg::KIND_TERM);
		advance   = !cmd_empty && (!valid_q || pop);
		cmd_pop   = advance && last;
		if (is_term) begin
			next_byte = hesc_pkg::CH_NUL;
		end else if (cmd.kind == hesc_pkg::KIND_PLAIN) begin
			next_byte = cmd.data;
		end else begin
			next_byte = hesc_pkg::ent_char(cmd.kind, idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q   <= last ? 3'd0 : idx_q + 3'd1;
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q  <= next_byte;
			last_q  <= last;
			end_q   <= is_term;
			count_q <= is_term ? cmd.count : 16'd0;
		end
	end

	assign empty         = !valid_q;
	assign out_byte      = byte_q;
	assign last_of_run   = last_q;
	assign string_end    = end_q;
	assign written_count = count_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_empty |-> (idx_q < len))
		else $error("expansion index runs past the entity length");

endmodule

`default_nettype wire

// ===== hw/rtl/html_escape_stream.sv =====
// Top level of the streaming HTML escaper: front end, command queue, back end.
// Uses hesc_pkg, hesc_front, hesc_queue and hesc_back.
// Each accepted byte is classified at once and, if it produces output, queued as
// one command; the back end expands commands into result items at one per cycle
// through its output register while that register is empty or popped. A plain
// byte gives one result item, an escaped byte four to six (its entity length),
// and a terminator one. The four-entry command queue lets the input keep taking
// bytes while an entity drains; input is held off only while the queue is full.
// A byte's first result is held in a queue entry and then the output register.
`default_nettype none

module html_escape_stream #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [15:0] cfg_data,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             string_end,
	output logic [15:0]      written_count
);

	hesc_pkg::cmd_t front_cmd;
	hesc_pkg::cmd_t head_cmd;
	logic           front_push;
	logic           q_empty;
	logic           q_pop;
	logic           accept;

	assign accept = push && !full;

	hesc_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_data (cfg_data),
		.accept   (accept),
		.in_byte  (in_byte),
		.cmd      (front_cmd),
		.cmd_push (front_push)
	);

	hesc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.wr_data(front_cmd),
		.full   (full),
		.pop    (q_pop),
		.rd_data(head_cmd),
		.empty  (q_empty)
	);

	hesc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (head_cmd),
		.cmd_empty    (q_empty),
		.cmd_pop      (q_pop),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.string_end   (string_end),
		.written_count(written_count)
	);

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for html_escape_stream: queued byte stimulus, a scoreboard
// predicting the escaped characters, and random push and pop idling.
// Depends on hesc_pkg and the html_escape_stream RTL.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_GAP = 16;

	typedef struct {
		logic [7:0]  ch;
		logic        last;
		logic        term;
		logic [15:0] count;
	} escaped_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [15:0] cfg_data = 16'd0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  in_byte = 8'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        string_end;
	logic [15:0] written_count;

	logic [7:0]    source_bytes[$];
	escaped_char_t expected_chars[$];
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	bit            push_taken = 1'b0;
	int            cycle_count = 0;
	int            errors = 0;

	logic [15:0] size_reg = 16'd256;
	logic [15:0] space_left = 16'd0;
	bit          string_open = 1'b0;
	bit          output_stopped = 1'b0;
	logic [15:0] bytes_written = 16'd0;

	html_escape_stream dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.in_byte(in_byte),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.string_end(string_end),
		.written_count(written_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void escape_byte(input logic [7:0] b);
		string         ent;
		logic [15:0]   need;
		escaped_char_t item;
		if (b == hesc_pkg::CH_NUL) begin
			item = '{ch: hesc_pkg::CH_NUL, last: 1'b1, term: 1'b1, count: bytes_written};
			expected_chars.push_back(item);
			space_left = 16'd0;
			string_open = 1'b0;
			output_stopped = 1'b0;
			bytes_written = 16'd0;
			return;
		end
		if (!string_open) begin
			string_open = 1'b1;
			output_stopped = 1'b0;
			bytes_written = 16'd0;
			space_left = (size_reg == 16'd0) ? 16'd0 : size_reg - 16'd1;
		end
		if (output_stopped)
			return;
		case (b)
			hesc_pkg::CH_QUOT: ent = "&quot;";
			hesc_pkg::CH_AMP:  ent = "&amp;";
			hesc_pkg::CH_LT:   ent = "&lt;";
			hesc_pkg::CH_GT:   ent = "&gt;";
			default:           ent = "";
		endcase
		need = (ent.len() == 0) ? 16'd1 : 16'(ent.len());
		if (space_left < need) begin
			output_stopped = 1'b1;
			return;
		end
		for (int i = 0; i < need; i++) begin
			item.ch = (ent.len() == 0) ? b : ent[i];
			item.last = (i == need - 1);
			item.term = 1'b0;
			item.count = 16'd0;
			expected_chars.push_back(item);
		end
		space_left = space_left - need;
		bytes_written = bytes_written + need;
		if (ent.len() == 0 && space_left == 16'd0)
			output_stopped = 1'b1;
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			pop <= 1'b0;
		end else begin
			if (!(push && !push_taken)) begin
				if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					push <= 1'b1;
					in_byte <= source_bytes[0];
				end else begin
					push <= 1'b0;
				end
			end
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		escaped_char_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			push_taken = arst_n && push && !full;
			if (arst_n && pop && !empty) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected item, expected none, got byte %h end %b count %0d",
						$time, out_byte, string_end, written_count);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					if (out_byte !== want.ch) begin
						$display("%0t: out_byte expected %h got %h", $time, want.ch, out_byte);
						errors++;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run expected %b got %b",
							$time, want.last, last_of_run);
						errors++;
					end
					if (string_end !== want.term) begin
						$display("%0t: string_end expected %b got %b",
							$time, want.term, string_end);
						errors++;
					end
					if (written_count !== want.count) begin
						$display("%0t: written_count expected %0d got %0d",
							$time, want.count, written_count);
						errors++;
					end
				end
			end
			if (push_taken) begin
				escape_byte(in_byte);
				void'(source_bytes.pop_front());
			end
		end
	end

	task automatic drain();
		while (source_bytes.size() != 0 || push || expected_chars.size() != 0)
			@(negedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic set_size(input logic [15:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		size_reg = value;
	endtask

	task automatic queue_text(input string s, input bit terminate);
		for (int i = 0; i < s.len(); i++)
			source_bytes.push_back(s[i]);
		if (terminate)
			source_bytes.push_back(hesc_pkg::CH_NUL);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return hesc_pkg::CH_QUOT;
		else if (r < 16)
			return hesc_pkg::CH_AMP;
		else if (r < 24)
			return hesc_pkg::CH_LT;
		else if (r < 32)
			return hesc_pkg::CH_GT;
		return 8'($urandom_range(255, 1));
	endfunction

	task automatic queue_strings(input int n_items);
		int added;
		int len;
		int lim;
		added = 0;
		while (added < n_items) begin
			lim = (size_reg < 20) ? size_reg + 3 : 20;
			len = $urandom_range(lim, 0);
			if ($urandom_range(9) == 0) begin
				for (int i = 0; i < len; i++)
					source_bytes.push_back(8'($urandom_range(255, 0)));
				added += len;
			end else begin
				for (int i = 0; i < len; i++)
					source_bytes.push_back(pick_char());
				source_bytes.push_back(hesc_pkg::CH_NUL);
				added += len + 1;
			end
		end
	endtask

	initial begin
		logic [15:0] sizes[8];
		int          idle_send[4];
		int          idle_recv[4];
		sizes = '{16'd65535, 16'd9, 16'd1, 16'd24, 16'd7, 16'd65535, 16'd2, 16'd40};
		idle_send = '{0, 80, 0, 14};
		idle_recv = '{0, 0, 80, 14};
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		set_size(16'd0);
		queue_text("\"", 1'b1);
		drain();
		set_size(16'd1);
		queue_text("x", 1'b1);
		queue_text("", 1'b1);
		drain();
		set_size(16'd256);
		source_bytes.push_back(hesc_pkg::CH_QUOT);
		source_bytes.push_back(hesc_pkg::CH_AMP);
		source_bytes.push_back(hesc_pkg::CH_LT);
		source_bytes.push_back(hesc_pkg::CH_GT);
		source_bytes.push_back(8'h01);
		source_bytes.push_back(8'h7F);
		source_bytes.push_back(8'h80);
		source_bytes.push_back(8'hFF);
		source_bytes.push_back(hesc_pkg::CH_NUL);
		drain();
		set_size(16'd6);
		queue_text("&a<", 1'b1);
		drain();
		set_size(16'd5);
		queue_text("\"b", 1'b1);
		drain();
		set_size(16'd10);
		queue_text("ab", 1'b0);
		drain();
		set_size(16'd2);
		queue_text("<cdef", 1'b1);
		queue_text("xy", 1'b1);
		drain();

		for (int p = 0; p < 8; p++) begin
			set_size(sizes[p]);
			send_idle_pct = idle_send[p % 4];
			recv_stall_pct = idle_recv[p % 4];
			queue_strings(36);
			drain();
		end

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
